/* rtl/core/nau_pkg.sv */
// Shared types and constants for the NNUE accumulator update block.
// No dependencies.
`default_nettype none
package nau_pkg;

  localparam int HIDDEN_DEF      = 128;
  localparam int FEATURES_DEF    = 1024;
  localparam int STACK_DEPTH_DEF = 128;

  localparam logic [2:0] OP_WR_WEIGHT = 3'd0;
  localparam logic [2:0] OP_ADD_SUB   = 3'd1;
  localparam logic [2:0] OP_ADD_SUB2  = 3'd2;
  localparam logic [2:0] OP_ADD2_SUB2 = 3'd3;
  localparam logic [2:0] OP_RD_LANE   = 3'd4;
  localparam logic [2:0] OP_WR_LANE   = 3'd5;

  // update sequence phases, one lane takes all six
  localparam logic [2:0] PH_SRC   = 3'd0;
  localparam logic [2:0] PH_ADD_A = 3'd1;
  localparam logic [2:0] PH_ADD_B = 3'd2;
  localparam logic [2:0] PH_SUB_A = 3'd3;
  localparam logic [2:0] PH_SUB_B = 3'd4;
  localparam logic [2:0] PH_WRITE = 3'd5;

  typedef struct packed {
    logic       load;      // capture input fields
    logic       reduce;    // one modulo step on rows and slots
    logic       upd;       // update sequence active
    logic [2:0] phase;
    logic       lane_clr;
    logic       lane_inc;
    logic       wt_wr;     // single weight write
    logic       acc_wr;    // single lane write
    logic       rd_issue;  // lane read from accumulator store
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic [2:0] opcode;
    logic       reduce_done;
    logic       last_lane;
    logic       out_free;
  } sts_t;

endpackage
`default_nettype wire

/* rtl/core/nau_ctrl.sv */
// Sequencer for the accumulator update block.
// Depends on nau_pkg.
`default_nettype none
module nau_ctrl
  import nau_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_REDUCE, S_UPD, S_RD_ISSUE, S_RD_CAP
  } state_t;

  state_t     state_r, state_nxt;
  logic [2:0] phase_r, phase_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    cmd       = '0;
    cmd.phase = phase_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_REDUCE;
        end
      end
      S_REDUCE: begin
        if (!sts.reduce_done) begin
          cmd.reduce = 1'b1;
        end else begin
          case (sts.opcode)
            OP_WR_WEIGHT: begin
              cmd.wt_wr = 1'b1;
              state_nxt = S_IDLE;
            end
            OP_WR_LANE: begin
              cmd.acc_wr = 1'b1;
              state_nxt = S_IDLE;
            end
            OP_ADD_SUB, OP_ADD_SUB2, OP_ADD2_SUB2: begin
              cmd.lane_clr = 1'b1;
              phase_nxt    = PH_SRC;
              state_nxt    = S_UPD;
            end
            OP_RD_LANE: state_nxt = S_RD_ISSUE;
            default:    state_nxt = S_IDLE;
          endcase
        end
      end
      S_UPD: begin
        cmd.upd = 1'b1;
        if (phase_r == PH_WRITE) begin
          phase_nxt = PH_SRC;
          if (sts.last_lane) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.lane_inc = 1'b1;
          end
        end else begin
          phase_nxt = phase_r + 3'd1;
        end
      end
      S_RD_ISSUE: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = S_RD_CAP;
      end
      S_RD_CAP: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= PH_SRC;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/nau_datapath.sv */
// Weight and accumulator memories, index reduction, lane arithmetic, result register.
// Depends on nau_pkg.
`default_nettype none
module nau_datapath
  import nau_pkg::*;
#(
  parameter int HIDDEN      = HIDDEN_DEF,
  parameter int FEATURES    = FEATURES_DEF,
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic [2:0]         in_opcode,
  input  wire logic [6:0]         in_dst_slot,
  input  wire logic [6:0]         in_src_slot,
  input  wire logic               in_perspective,
  input  wire logic [9:0]         in_add_row_a,
  input  wire logic [9:0]         in_add_row_b,
  input  wire logic [9:0]         in_sub_row_a,
  input  wire logic [9:0]         in_sub_row_b,
  input  wire logic [6:0]         in_lane,
  input  wire logic signed [15:0] in_value,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [15:0]      out_read_value,
  input  wire cmd_t               cmd,
  output sts_t                    sts
);

  localparam int LANE_W = (HIDDEN > 1) ? $clog2(HIDDEN) : 1;
  localparam int ROW_W  = $clog2(FEATURES);
  localparam int SLOT_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int LX_W   = (LANE_W > 7) ? LANE_W : 7;
  localparam int RX_W   = (ROW_W > 10) ? ROW_W : 10;
  localparam int SX_W   = (SLOT_W > 7) ? SLOT_W : 7;
  localparam int WA_W   = ROW_W + LANE_W;
  localparam int AA_W   = SLOT_W + 1 + LANE_W;

  logic [15:0] wt_mem  [2**WA_W];
  logic [15:0] acc_mem [2**AA_W];

  logic [2:0]        op_r;
  logic [SX_W-1:0]   dst_r, src_r;
  logic              persp_r;
  logic [RX_W-1:0]   row_r [4];
  logic [LX_W-1:0]   lane_r;
  logic [15:0]       value_r;
  logic [LANE_W-1:0] cnt_r;
  logic [15:0]       sum_r, wt_q_r, acc_q_r;
  logic              out_valid_r;
  logic [15:0]       out_r;

  logic              lane_ok;
  logic [LANE_W-1:0] lane_idx;
  logic [3:0]        row_big;
  logic              dst_big, src_big;
  logic [ROW_W-1:0]  wt_row;
  logic [1:0]        row_sel;
  logic [15:0]       upd_wdata;

  assign lane_ok  = ((LX_W+1)'(lane_r) < (LX_W+1)'(HIDDEN));
  assign lane_idx = lane_r[LANE_W-1:0];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      row_big[i] = ((RX_W+1)'(row_r[i]) >= (RX_W+1)'(FEATURES));
    end
  end
  assign dst_big = ((SX_W+1)'(dst_r) >= (SX_W+1)'(STACK_DEPTH));
  assign src_big = ((SX_W+1)'(src_r) >= (SX_W+1)'(STACK_DEPTH));

  assign sts.opcode      = op_r;
  assign sts.reduce_done = !(|row_big) && !dst_big && !src_big;
  assign sts.last_lane   = (cnt_r == LANE_W'(HIDDEN - 1));
  assign sts.out_free    = !out_valid_r || !out_stall;

  // phase k reads the weight row of list entry k-1
  assign row_sel = 2'(cmd.phase - 3'd1);
  assign wt_row  = row_r[row_sel][ROW_W-1:0];

  // last subtract folds into the write-back
  assign upd_wdata = (op_r == OP_ADD_SUB) ? sum_r : (sum_r - wt_q_r);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= in_opcode;
      dst_r    <= SX_W'(in_dst_slot);
      src_r    <= SX_W'(in_src_slot);
      persp_r  <= in_perspective;
      row_r[0] <= RX_W'(in_add_row_a);
      row_r[1] <= RX_W'(in_add_row_b);
      row_r[2] <= RX_W'(in_sub_row_a);
      row_r[3] <= RX_W'(in_sub_row_b);
      lane_r   <= LX_W'(in_lane);
      value_r  <= in_value;
    end else if (cmd.reduce) begin
      for (int i = 0; i < 4; i++) begin
        if (row_big[i]) row_r[i] <= row_r[i] - RX_W'(FEATURES);
      end
      if (dst_big) dst_r <= dst_r - SX_W'(STACK_DEPTH);
      if (src_big) src_r <= src_r - SX_W'(STACK_DEPTH);
    end

    if (cmd.lane_clr) begin
      cnt_r <= '0;
    end else if (cmd.lane_inc) begin
      cnt_r <= cnt_r + LANE_W'(1);
    end

    if (cmd.upd) begin
      case (cmd.phase)
        PH_ADD_A: sum_r <= acc_q_r;
        PH_ADD_B: sum_r <= sum_r + wt_q_r;
        PH_SUB_A: if (op_r == OP_ADD2_SUB2) sum_r <= sum_r + wt_q_r;
        PH_SUB_B: sum_r <= sum_r - wt_q_r;
        default:  sum_r <= sum_r;
      endcase
    end

    // weight memory
    if (cmd.wt_wr && lane_ok) begin
      wt_mem[{row_r[0][ROW_W-1:0], lane_idx}] <= value_r;
    end
    if (cmd.upd && cmd.phase != PH_SRC && cmd.phase != PH_WRITE) begin
      wt_q_r <= wt_mem[{wt_row, cnt_r}];
    end

    // accumulator memory
    if (cmd.acc_wr && lane_ok) begin
      acc_mem[{dst_r[SLOT_W-1:0], persp_r, lane_idx}] <= value_r;
    end else if (cmd.upd && cmd.phase == PH_WRITE) begin
      acc_mem[{dst_r[SLOT_W-1:0], persp_r, cnt_r}] <= upd_wdata;
    end
    if (cmd.upd && cmd.phase == PH_SRC) begin
      acc_q_r <= acc_mem[{src_r[SLOT_W-1:0], persp_r, cnt_r}];
    end else if (cmd.rd_issue) begin
      acc_q_r <= acc_mem[{dst_r[SLOT_W-1:0], persp_r, lane_idx}];
    end

    if (cmd.out_load) begin
      out_r <= lane_ok ? acc_q_r : 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = out_r;

endmodule
`default_nettype wire

/* rtl/core/nnue_accumulator_update.sv */
// Top level of the NNUE incremental accumulator update block.
// Depends on nau_pkg, nau_ctrl, nau_datapath.
`default_nettype none
// One opcode per input transfer. Weight writes and lane writes store one
// 16-bit element; update opcodes rebuild a whole destination vector lane by
// lane as src + adds - subs with 16-bit wraparound; a lane read returns one
// output transfer. Every item is first captured, then its row and slot
// indices are normalized by modulo steps (none when all indices are already
// in range, otherwise at most the larger of ceil(1024 / FEATURES) - 1 and
// ceil(128 / STACK_DEPTH) - 1 steps). A write then stores its element; a
// read issues an accumulator read and then loads the result register,
// waiting while out_stall still holds that register. An update clears the
// lane counter, then per lane does one accumulator read and four weight
// reads through the single weight memory port, then one write-back. Input is
// accepted only between items; a finished read result waits in its own
// register, so the next item is accepted while it is pending. Both stores
// power up undefined: read only what was written.
module nnue_accumulator_update
  import nau_pkg::*;
#(
  parameter int HIDDEN      = HIDDEN_DEF,
  parameter int FEATURES    = FEATURES_DEF,
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [2:0]         in_opcode,
  input  wire logic [6:0]         in_dst_slot,
  input  wire logic [6:0]         in_src_slot,
  input  wire logic               in_perspective,
  input  wire logic [9:0]         in_add_row_a,
  input  wire logic [9:0]         in_add_row_b,
  input  wire logic [9:0]         in_sub_row_a,
  input  wire logic [9:0]         in_sub_row_b,
  input  wire logic [6:0]         in_lane,
  input  wire logic signed [15:0] in_value,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [15:0]      out_read_value
);

  cmd_t cmd;
  sts_t sts;

  nau_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  nau_datapath #(
    .HIDDEN      (HIDDEN),
    .FEATURES    (FEATURES),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_opcode      (in_opcode),
    .in_dst_slot    (in_dst_slot),
    .in_src_slot    (in_src_slot),
    .in_perspective (in_perspective),
    .in_add_row_a   (in_add_row_a),
    .in_add_row_b   (in_add_row_b),
    .in_sub_row_a   (in_sub_row_a),
    .in_sub_row_b   (in_sub_row_b),
    .in_lane        (in_lane),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_read_value (out_read_value),
    .cmd            (cmd),
    .sts            (sts)
  );

endmodule
`default_nettype wire

/* tb/testbench.sv */
// Self-checking testbench for nnue_accumulator_update: a queue-fed driver,
// an output monitor and a behavioral model of both stores.
// Depends on nau_pkg and the nnue_accumulator_update RTL.
`timescale 1ns / 1ps
module testbench
  import nau_pkg::*;
();

  localparam int HID   = 128;
  localparam int FEAT  = 1024;
  localparam int DEPTH = 128;
  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;

  typedef struct {
    logic [2:0]         op;
    logic [6:0]         dst;
    logic [6:0]         src;
    logic               persp;
    logic [9:0]         add_a;
    logic [9:0]         add_b;
    logic [9:0]         sub_a;
    logic [9:0]         sub_b;
    logic [6:0]         lane;
    logic signed [15:0] value;
  } acc_op_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] in_opcode = '0;
  logic [6:0] in_dst_slot = '0;
  logic [6:0] in_src_slot = '0;
  logic in_perspective = 1'b0;
  logic [9:0] in_add_row_a = '0;
  logic [9:0] in_add_row_b = '0;
  logic [9:0] in_sub_row_a = '0;
  logic [9:0] in_sub_row_b = '0;
  logic [6:0] in_lane = '0;
  logic signed [15:0] in_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] out_read_value;

  nnue_accumulator_update uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_opcode(in_opcode), .in_dst_slot(in_dst_slot), .in_src_slot(in_src_slot),
    .in_perspective(in_perspective),
    .in_add_row_a(in_add_row_a), .in_add_row_b(in_add_row_b),
    .in_sub_row_a(in_sub_row_a), .in_sub_row_b(in_sub_row_b),
    .in_lane(in_lane), .in_value(in_value),
    .out_valid(out_valid), .out_stall(out_stall), .out_read_value(out_read_value)
  );

  always #6 clk = ~clk;

  // model of both stores, updated at each accepted input transfer
  logic [15:0] weight_mem [0:FEAT*HID-1];
  logic [15:0] acc_mem [0:DEPTH*2*HID-1];
  logic [15:0] lane_reads_due [$];
  acc_op_t     pending_ops [$];

  int  errors = 0;
  int  cycle = 0;
  logic in_took = 1'b0;

  // generator bookkeeping: which vectors are fully written, and the row pool
  int full_vecs [$];
  int row_pool [4] = '{0, 1023, 341, 682};

  task automatic apply_op(input acc_op_t t);
    int d;
    int s;
    logic [15:0] v;
    d = (int'(t.dst) % DEPTH * 2 + t.persp) * HID;
    s = (int'(t.src) % DEPTH * 2 + t.persp) * HID;
    case (t.op)
      OP_WR_WEIGHT: if (t.lane < HID) weight_mem[(t.add_a % FEAT) * HID + t.lane] = t.value;
      OP_WR_LANE:   if (t.lane < HID) acc_mem[d + t.lane] = t.value;
      OP_RD_LANE:   lane_reads_due.push_back(t.lane < HID ? acc_mem[d + t.lane] : 16'd0);
      OP_ADD_SUB, OP_ADD_SUB2, OP_ADD2_SUB2: begin
        for (int i = 0; i < HID; i++) begin
          v = acc_mem[s + i] + weight_mem[(t.add_a % FEAT) * HID + i]
              - weight_mem[(t.sub_a % FEAT) * HID + i];
          if (t.op != OP_ADD_SUB) v = v - weight_mem[(t.sub_b % FEAT) * HID + i];
          if (t.op == OP_ADD2_SUB2) v = v + weight_mem[(t.add_b % FEAT) * HID + i];
          acc_mem[d + i] = v;
        end
      end
      default: ;
    endcase
  endtask

  function automatic acc_op_t rand_fields(input logic [2:0] op);
    acc_op_t t;
    t.op = op; t.dst = 7'($urandom); t.src = 7'($urandom); t.persp = 1'($urandom);
    t.add_a = 10'($urandom); t.add_b = 10'($urandom);
    t.sub_a = 10'($urandom); t.sub_b = 10'($urandom);
    t.lane = 7'($urandom); t.value = 16'($urandom);
    return t;
  endfunction

  function automatic int pool_row();
    return row_pool[$urandom_range(0, 3)];
  endfunction

  // update from a fully written source through pool rows only
  task automatic queue_update(input logic [2:0] op, input bit same_slot);
    acc_op_t t;
    int sv;
    int dv;
    bit seen;
    t = rand_fields(op);
    sv = full_vecs[$urandom_range(0, full_vecs.size() - 1)];
    t.src = 7'(sv / 2); t.persp = 1'(sv % 2);
    if (same_slot) t.dst = t.src;
    t.add_a = 10'(pool_row()); t.add_b = 10'(pool_row());
    t.sub_a = 10'(pool_row()); t.sub_b = 10'(pool_row());
    dv = t.dst * 2 + t.persp;
    seen = 1'b0;
    foreach (full_vecs[i]) if (full_vecs[i] == dv) seen = 1'b1;
    if (!seen) full_vecs.push_back(dv);
    pending_ops.push_back(t);
  endtask

  task automatic queue_read(input bit beyond);
    acc_op_t t;
    int vv;
    t = rand_fields(OP_RD_LANE);
    if (beyond) t.lane = 7'($urandom_range(HID, 127 + HID) % 128);
    if (!beyond) begin
      vv = full_vecs[$urandom_range(0, full_vecs.size() - 1)];
      t.dst = 7'(vv / 2); t.persp = 1'(vv % 2); t.lane = 7'($urandom_range(0, HID - 1));
    end
    pending_ops.push_back(t);
  endtask

  // stimulus
  initial begin
    acc_op_t t;
    int pick;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // fill the weight row pool and two source vectors
    foreach (row_pool[r])
      for (int l = 0; l < HID; l++) begin
        t = rand_fields(OP_WR_WEIGHT);
        t.add_a = 10'(row_pool[r]); t.lane = 7'(l);
        if (l == 0) t.value = 16'sh7fff;
        if (l == 1) t.value = -16'sd32768;
        pending_ops.push_back(t);
      end
    for (int l = 0; l < HID; l++) begin
      t = rand_fields(OP_WR_LANE);
      t.dst = 7'd0; t.persp = 1'b0; t.lane = 7'(l);
      if (l < 2) t.value = l ? -16'sd32768 : 16'sh7fff;
      pending_ops.push_back(t);
      t = rand_fields(OP_WR_LANE);
      t.dst = 7'd127; t.persp = 1'b1; t.lane = 7'(l);
      pending_ops.push_back(t);
    end
    full_vecs.push_back(0);
    full_vecs.push_back(255);

    // directed corner cases
    queue_read(1'b0);
    t = rand_fields(OP_RD_LANE); t.dst = 7'd0; t.persp = 1'b0; t.lane = 7'd0;
    pending_ops.push_back(t);
    t.lane = 7'd1; pending_ops.push_back(t);
    queue_update(OP_ADD_SUB, 1'b0);
    queue_update(OP_ADD_SUB2, 1'b0);
    queue_update(OP_ADD2_SUB2, 1'b1);   // in-place update
    t = rand_fields(OP_WR_WEIGHT); t.lane = 7'd127; t.add_a = 10'd1023; pending_ops.push_back(t);
    t = rand_fields(OP_WR_LANE); t.dst = 7'd0; t.persp = 1'b0; t.lane = 7'd127;
    t.value = -16'sd32768; pending_ops.push_back(t);
    t = rand_fields(OP_RD_LANE); t.dst = 7'd0; t.persp = 1'b0; t.lane = 7'd127;
    pending_ops.push_back(t);
    pending_ops.push_back(rand_fields(OP_SPARE6));
    pending_ops.push_back(rand_fields(OP_SPARE7));
    queue_update(OP_ADD2_SUB2, 1'b0);
    for (int k = 0; k < 4; k++) queue_read(1'b0);

    // random mix
    for (int n = 0; n < 980; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 5) queue_update(3'(OP_ADD_SUB + $urandom_range(0, 2)),
                                 $urandom_range(0, 7) == 0);
      else if (pick < 35) begin
        t = rand_fields(OP_WR_WEIGHT);
        if ($urandom_range(0, 1)) t.add_a = 10'(pool_row());
        pending_ops.push_back(t);
      end else if (pick < 58) pending_ops.push_back(rand_fields(OP_WR_LANE));
      else if (pick < 95) queue_read(1'b0);
      else pending_ops.push_back(rand_fields($urandom_range(0, 1) ? OP_SPARE6 : OP_SPARE7));
    end

    while (pending_ops.size() != 0 || in_valid || lane_reads_due.size() != 0)
      @(posedge clk);
    repeat (1000) @(posedge clk);
    if (errors == 0 && lane_reads_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // idling except in a quiet stretch
  function automatic bit idle_now();
    if (cycle > 4000 && cycle < 12000) return 1'b0;
    return $urandom_range(0, 99) < 6;
  endfunction

  // input transfer bookkeeping and prediction
  always @(posedge clk) begin
    cycle <= cycle + 1;
    in_took <= in_valid && !in_stall && rst_n;
    if (rst_n && in_valid && !in_stall) begin
      apply_op('{in_opcode, in_dst_slot, in_src_slot, in_perspective, in_add_row_a,
                 in_add_row_b, in_sub_row_a, in_sub_row_b, in_lane, in_value});
    end
  end

  // driver
  always @(negedge clk) begin
    acc_op_t t;
    out_stall <= rst_n && idle_now();
    if (rst_n && (!in_valid || in_took)) begin
      if (pending_ops.size() != 0 && !idle_now()) begin
        t = pending_ops.pop_front();
        in_valid <= 1'b1;
        in_opcode <= t.op; in_dst_slot <= t.dst; in_src_slot <= t.src;
        in_perspective <= t.persp; in_add_row_a <= t.add_a; in_add_row_b <= t.add_b;
        in_sub_row_a <= t.sub_a; in_sub_row_b <= t.sub_b; in_lane <= t.lane;
        in_value <= t.value;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    logic [15:0] want;
    if (rst_n && out_valid && !out_stall) begin
      if (lane_reads_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected read result %0d", out_read_value);
      end else begin
        want = lane_reads_due.pop_front();
        if (out_read_value !== want) begin
          errors++;
          if (errors <= 10)
            $display("read_value mismatch: expected %0d got %0d",
                     $signed(want), out_read_value);
        end
      end
    end
  end

  initial begin
    #30_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
